FILE: design/srx_pkg.sv
// shared types, codes and report builder for the stuffed frame receiver
`timescale 1ns / 1ps
`default_nettype none

package srx_pkg;

  localparam int unsigned HeaderBytes = 5;
  localparam int unsigned OpcodeBytes = 2;

  typedef enum logic [2:0] {
    IDX_SYNC     = 3'd0,
    IDX_ESCAPE   = 3'd1,
    IDX_ESC_SYNC = 3'd2,
    IDX_MSG_TYPE = 3'd3,
    IDX_ACK_TYPE = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_GOOD    = 3'd0,
    ST_BAD_SUM = 3'd1,
    ST_SHORT   = 3'd2,
    ST_ACK     = 3'd3,
    ST_OTHER   = 3'd4,
    ST_BAD_ESC = 3'd5
  } status_e;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] escape_value;
    logic [7:0] escaped_sync_value;
    logic [7:0] message_type_code;
    logic [7:0] ack_type_code;
  } srx_cfg_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  data_byte;
    logic [2:0]  frame_status;
    logic [7:0]  seq_number;
    logic [7:0]  frm_type;
    logic [15:0] op_code;
    logic        send_ack;
  } srx_result_t;

  function automatic srx_result_t make_report(status_e status, logic ack, logic [7:0] seq,
                                              logic [7:0] ftype, logic [15:0] opcode,
                                              logic have_opcode);
    srx_result_t r;
    r.out_kind     = KIND_REPORT;
    r.data_byte    = 8'h00;
    r.frame_status = status;
    r.seq_number   = seq;
    r.frm_type     = ftype;
    r.op_code      = have_opcode ? opcode : 16'h0000;
    r.send_ack     = ack;
    return r;
  endfunction

  function automatic srx_result_t make_data(logic [7:0] b);
    srx_result_t r;
    r              = '0;
    r.out_kind     = KIND_DATA;
    r.data_byte    = b;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/srx_if.sv
// byte input channel and result output channel
`timescale 1ns / 1ps
`default_nettype none

interface srx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface srx_res_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  data_byte;
  logic [2:0]  frame_status;
  logic [7:0]  seq_number;
  logic [7:0]  frm_type;
  logic [15:0] op_code;
  logic        send_ack;

  modport source (output valid, output out_kind, output data_byte, output frame_status,
                  output seq_number, output frm_type, output op_code, output send_ack,
                  input ready);
  modport sink (input valid, input out_kind, input data_byte, input frame_status,
                input seq_number, input frm_type, input op_code, input send_ack,
                output ready);
endinterface

`default_nettype wire

FILE: design/stuffed_frame_receiver.sv
// stuffed frame receiver: sync hunt, unescape, header parse, cut-through payload, checksum report
//
// rx_i carries raw bytes from the serial line, one per transfer. res_o carries
// results: a data result for every payload byte after the two opcode bytes, and
// one end-of-frame report per frame (checksum byte or bad escape). Bytes that
// cause no result (sync, header, escapes, opcode) produce nothing on res_o.
// Each accepted byte is processed in the cycle it is taken; its result appears
// in the output register in the next cycle. One byte per cycle is sustained
// while res_o does not stall: the state update is a single pass of compares
// and an 8-bit add ahead of the result register.
// rx_i.ready is high while the output register is empty or being emptied, so
// a stall on res_o holds at most one result and backs up the input only then.
// Reset puts the block in sync hunt with cleared frame state and loads the
// default sync, escape, escaped-sync and type codes. Configuration writes on
// cfg_we_i / cfg_idx_i / cfg_data_i take effect at the next clock edge and are
// meant to happen while no frame is in flight.
`timescale 1ns / 1ps
`default_nettype none

module stuffed_frame_receiver (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  srx_byte_if.sink        rx_i,
  srx_res_if.source       res_o
);
  import srx_pkg::*;

  srx_cfg_t cfg;

  srx_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [2:0]  hdr_q, hdr_d;
  logic [7:0]  rem_q, rem_d;
  logic [1:0]  off_q, off_d;     // payload offset, saturates at two
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] opc_q, opc_d;

  logic        res_valid_q;
  srx_result_t res_q, res_d;
  logic        emit;

  logic        accept;
  logic        take;
  logic [7:0]  tb;
  logic [7:0]  sum_next;
  logic        have_opc;

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign have_opc   = (off_q == 2'(OpcodeBytes));
  // unescaped byte value, an escaped escape is the raw byte itself
  assign tb         = (esc_q && (rx_i.rx_byte == cfg.escaped_sync_value)) ?
                      cfg.sync_value : rx_i.rx_byte;
  assign sum_next   = sum_q + tb;

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    hdr_d   = hdr_q;
    rem_d   = rem_q;
    off_d   = off_q;
    sum_d   = sum_q;
    seq_d   = seq_q;
    type_d  = type_q;
    len_d   = len_q;
    opc_d   = opc_q;
    emit    = 1'b0;
    res_d   = '0;
    take    = 1'b0;

    if (accept) begin
      if (phase_q == PH_HUNT) begin
        if (rx_i.rx_byte == cfg.sync_value) begin
          phase_d = PH_HEADER;
          esc_d   = 1'b0;
          hdr_d   = '0;
          rem_d   = '0;
          off_d   = '0;
          sum_d   = rx_i.rx_byte;
          seq_d   = '0;
          type_d  = '0;
          len_d   = '0;
          opc_d   = '0;
        end
      end else if (esc_q) begin
        esc_d = 1'b0;
        priority if (rx_i.rx_byte == cfg.escaped_sync_value) begin
          take = 1'b1;
        end else if (rx_i.rx_byte == cfg.escape_value) begin
          take = 1'b1;
        end else begin
          // broken escape pair ends the frame
          phase_d = PH_HUNT;
          emit    = 1'b1;
          res_d   = make_report(ST_BAD_ESC, 1'b0, seq_q, type_q, opc_q, have_opc);
        end
      end else if (rx_i.rx_byte == cfg.escape_value) begin
        esc_d = 1'b1;
      end else begin
        take = 1'b1;
      end
    end

    if (take) begin
      sum_d = sum_next;
      unique case (phase_q)
        PH_HEADER: begin
          if (hdr_q == 3'd2) seq_d = tb;
          if (hdr_q == 3'd3) type_d = tb;
          if (hdr_q == 3'd4) len_d = tb;
          hdr_d = hdr_q + 3'd1;
          if (hdr_q == 3'(HeaderBytes - 1)) begin
            rem_d   = tb;
            off_d   = '0;
            phase_d = (tb == 8'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          unique case (off_q)
            2'd0:    opc_d = {tb, 8'h00};
            2'd1:    opc_d = {opc_q[15:8], tb};
            default: begin
              emit  = 1'b1;
              res_d = make_data(tb);
            end
          endcase
          if (!have_opc) off_d = off_q + 2'd1;
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) phase_d = PH_CHECK;
        end
        PH_CHECK: begin
          phase_d = PH_HUNT;
          emit    = 1'b1;
          priority if (sum_next != 8'd0) begin
            res_d = make_report(ST_BAD_SUM, 1'b0, seq_q, type_q, opc_q, have_opc);
          end else if (type_q == cfg.message_type_code) begin
            res_d = make_report((len_q < 8'(OpcodeBytes)) ? ST_SHORT : ST_GOOD, 1'b1,
                                seq_q, type_q, opc_q, have_opc);
          end else if (type_q == cfg.ack_type_code) begin
            res_d = make_report(ST_ACK, 1'b0, seq_q, type_q, opc_q, have_opc);
          end else begin
            res_d = make_report(ST_OTHER, 1'b0, seq_q, type_q, opc_q, have_opc);
          end
        end
        default: begin
          // no byte is taken while hunting
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      esc_q       <= 1'b0;
      hdr_q       <= '0;
      rem_q       <= '0;
      off_q       <= '0;
      sum_q       <= '0;
      seq_q       <= '0;
      type_q      <= '0;
      len_q       <= '0;
      opc_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      hdr_q   <= hdr_d;
      rem_q   <= rem_d;
      off_q   <= off_d;
      sum_q   <= sum_d;
      seq_q   <= seq_d;
      type_q  <= type_d;
      len_q   <= len_d;
      opc_q   <= opc_d;
      if (accept) begin
        res_valid_q <= emit;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.out_kind     = res_q.out_kind;
  assign res_o.data_byte    = res_q.data_byte;
  assign res_o.frame_status = res_q.frame_status;
  assign res_o.seq_number   = res_q.seq_number;
  assign res_o.frm_type     = res_q.frm_type;
  assign res_o.op_code      = res_q.op_code;
  assign res_o.send_ack     = res_q.send_ack;

  // a byte taken while hunting never produces a result
  a_hunt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PH_HUNT) |=> !res_o.valid)
    else $error("result produced by a byte taken during sync hunt");

  // an escape can only be pending inside a frame
  a_esc_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> phase_q != PH_HUNT)
    else $error("escape pending while hunting");

  // header counter stays within the header
  a_hdr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_q <= 3'(HeaderBytes))
    else $error("header index past header length");

  // data results only come out of the payload phase
  a_data_from_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit && res_d.out_kind == KIND_DATA) |-> phase_q == PH_PAYLOAD)
    else $error("data result outside payload");

  // a short message report always asks for an ack
  a_short_acks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.out_kind == KIND_REPORT && res_o.frame_status == ST_SHORT)
      |-> res_o.send_ack)
    else $error("short payload report without ack request");

endmodule

`default_nettype wire

FILE: design/srx_cfg_regs.sv
// configuration register file for the stuffed frame receiver
`timescale 1ns / 1ps
`default_nettype none

module srx_cfg_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [7:0]       cfg_data_i,
  output srx_pkg::srx_cfg_t     cfg_o
);
  import srx_pkg::*;

  srx_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      // indexes past the list are dropped
      unique case (cfg_idx_i)
        IDX_SYNC:     cfg_d.sync_value         = cfg_data_i;
        IDX_ESCAPE:   cfg_d.escape_value       = cfg_data_i;
        IDX_ESC_SYNC: cfg_d.escaped_sync_value = cfg_data_i;
        IDX_MSG_TYPE: cfg_d.message_type_code  = cfg_data_i;
        IDX_ACK_TYPE: cfg_d.ack_type_code      = cfg_data_i;
        default:      cfg_d                    = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value         <= 8'd164;
      cfg_q.escape_value       <= 8'd27;
      cfg_q.escaped_sync_value <= 8'd83;
      cfg_q.message_type_code  <= 8'd0;
      cfg_q.ack_type_code      <= 8'd128;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire
